[rtl/core/bucket_queue_distance_transform_macros.svh]
// Assertion macros used by the RTL of the distance transform.
`ifndef BUCKET_QUEUE_DISTANCE_TRANSFORM_MACROS_SVH
`define BUCKET_QUEUE_DISTANCE_TRANSFORM_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BQDT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BQDT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BQDT_ASSERT_IMP(lbl, ante, cons)
`define BQDT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/bqdt_pkg.sv]
package bqdt_pkg;

    localparam int DIST_W   = 16;
    localparam int DIM_W    = 7;
    localparam int COORD_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0]  DIM_RESET = 7'd64;
    localparam logic [DIST_W-1:0] FAR_RESET = 16'd666;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_RD_CAP,
        ST_NB,
        ST_CUR,
        ST_WR
    } t_state;

endpackage

[rtl/core/bucket_queue_distance_transform.sv]
// City-block distance transform. Pixels are loaded one per item in raster order
// (no result). After the last pixel of the frame the block relaxes the map in a
// forward and a backward raster pass through its distance memory (one write and
// one read port): per pixel it reads the neighbor across rows, then the pixel, then
// writes it back. It is busy for the whole sweep and accepts nothing meanwhile,
// neither items nor register writes. A read item passes through the address
// register, the memory read and the output register and returns the stored
// distance, already capped by the far value in force when that pixel was
// loaded, with a flag set once the map is complete; reads outside the image return 0.
`include "bucket_queue_distance_transform_macros.svh"

module bucket_queue_distance_transform #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bqdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bqdt_pkg::DIST_W-1:0]      i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic                             i_pixel,
    input  logic [bqdt_pkg::COORD_W-1:0]     i_row,
    input  logic [bqdt_pkg::COORD_W-1:0]     i_col,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bqdt_pkg::DIST_W-1:0]      o_distance,
    output logic                             o_ready_res
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DW    = bqdt_pkg::DIST_W;

    logic [DW-1:0] mem [DEPTH];

    bqdt_pkg::t_state r_state, n_state;
    logic [bqdt_pkg::DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic [DW-1:0] r_far;
    logic [AW:0]   r_lpos, n_lpos;
    logic          r_done, n_done;
    logic [AW-1:0] r_raddr, n_raddr;
    logic          r_oob, n_oob;
    logic [AW-1:0] r_pi, n_pi;
    logic [RW-1:0] r_pr, n_pr;
    logic [CW-1:0] r_pc, n_pc;
    logic          r_back, n_back;
    logic [DW-1:0] r_nb, n_nb;
    logic          r_nbv, n_nbv;
    logic [DW-1:0] r_prev, n_prev;
    logic [DW-1:0] r_rdata;
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_dist, n_dist;
    logic          r_rdy, n_rdy;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [CW-1:0] w_m1;
    logic [RW-1:0] h_m1;
    logic [AW:0]   total;
    logic [AW:0]   pos_eff, pos_nxt;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_we;
    logic          in_acc;
    logic          nb_valid, side_valid;
    logic [DW:0]   cand_nb, cand_side;
    logic [DW-1:0] relaxed;

    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_cfg_h);
        end
    end

    assign w_m1  = CW'(eff_w - WW'(1));
    assign h_m1  = RW'(eff_h - HW'(1));
    assign total = (AW + 1)'(32'(eff_w) * 32'(eff_h));

    // The geometry must not move under a running sweep.
    assign o_cfg_ready = (r_state == bqdt_pkg::ST_IDLE);
    assign o_in_ready  = (r_state == bqdt_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;

    assign pos_eff = (r_lpos >= total) ? '0 : r_lpos;
    assign pos_nxt = pos_eff + (AW + 1)'(1);

    // Neighbor across rows comes from memory; the neighbor along the row is
    // the value written one step earlier and is held in r_prev.
    assign nb_valid   = r_back ? (r_pr != h_m1) : (r_pr != '0);
    assign side_valid = r_back ? (r_pc != w_m1) : (r_pc != '0);
    assign cand_nb    = {1'b0, r_nb} + (DW + 1)'(1);
    assign cand_side  = {1'b0, r_prev} + (DW + 1)'(1);

    always_comb begin
        relaxed = r_rdata;
        if (r_nbv && (cand_nb < {1'b0, relaxed})) begin
            relaxed = cand_nb[DW-1:0];
        end
        if (side_valid && (cand_side < {1'b0, relaxed})) begin
            relaxed = cand_side[DW-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_lpos      = r_lpos;
        n_done      = r_done;
        n_raddr     = r_raddr;
        n_oob       = r_oob;
        n_pi        = r_pi;
        n_pr        = r_pr;
        n_pc        = r_pc;
        n_back      = r_back;
        n_nb        = r_nb;
        n_nbv       = r_nbv;
        n_prev      = r_prev;
        n_dist      = r_dist;
        n_rdy       = r_rdy;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_waddr   = r_pi;
        mem_wdata   = relaxed;
        mem_raddr   = r_raddr;

        unique case (r_state)
            bqdt_pkg::ST_IDLE: begin
                if (in_acc && !i_kind) begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_eff[AW-1:0];
                    mem_wdata = i_pixel ? '0 : r_far;
                    if (pos_eff == '0) begin
                        n_done = 1'b0;
                    end
                    if (pos_nxt == total) begin
                        n_lpos  = '0;
                        n_pi    = '0;
                        n_pr    = '0;
                        n_pc    = '0;
                        n_back  = 1'b0;
                        n_state = bqdt_pkg::ST_NB;
                    end else begin
                        n_lpos = pos_nxt;
                    end
                end else if (in_acc) begin
                    n_oob   = !((32'(i_row) < 32'(eff_h)) && (32'(i_col) < 32'(eff_w)));
                    n_raddr = AW'(32'(i_row) * 32'(eff_w) + 32'(i_col));
                    n_state = bqdt_pkg::ST_RD_WAIT;
                end
            end
            bqdt_pkg::ST_RD_WAIT: begin
                n_state = bqdt_pkg::ST_RD_CAP;
            end
            bqdt_pkg::ST_RD_CAP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_dist      = r_oob ? '0 : r_rdata;
                    n_rdy       = r_done;
                    n_state     = bqdt_pkg::ST_IDLE;
                end
            end
            bqdt_pkg::ST_NB: begin
                mem_raddr = r_back ? AW'({1'b0, r_pi} + (AW + 1)'(eff_w))
                                   : AW'({1'b0, r_pi} - (AW + 1)'(eff_w));
                n_nbv     = nb_valid;
                n_state   = bqdt_pkg::ST_CUR;
            end
            bqdt_pkg::ST_CUR: begin
                mem_raddr = r_pi;
                n_nb      = r_rdata;
                n_state   = bqdt_pkg::ST_WR;
            end
            bqdt_pkg::ST_WR: begin
                mem_we  = 1'b1;
                n_prev  = relaxed;
                n_state = bqdt_pkg::ST_NB;
                if (!r_back) begin
                    if ({1'b0, r_pi} == total - (AW + 1)'(1)) begin
                        // Backward pass starts on the last pixel, where we already are.
                        n_back = 1'b1;
                    end else if (r_pc == w_m1) begin
                        n_pc = '0;
                        n_pr = r_pr + RW'(1);
                        n_pi = r_pi + AW'(1);
                    end else begin
                        n_pc = r_pc + CW'(1);
                        n_pi = r_pi + AW'(1);
                    end
                end else begin
                    if (r_pi == '0) begin
                        n_done  = 1'b1;
                        n_state = bqdt_pkg::ST_IDLE;
                    end else if (r_pc == '0) begin
                        n_pc = w_m1;
                        n_pr = r_pr - RW'(1);
                        n_pi = r_pi - AW'(1);
                    end else begin
                        n_pc = r_pc - CW'(1);
                        n_pi = r_pi - AW'(1);
                    end
                end
            end
            default: begin
                n_state = bqdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bqdt_pkg::ST_IDLE;
            r_cfg_w     <= bqdt_pkg::DIM_RESET;
            r_cfg_h     <= bqdt_pkg::DIM_RESET;
            r_far       <= bqdt_pkg::FAR_RESET;
            r_lpos      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lpos      <= n_lpos;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                priority case (i_cfg_index)
                    bqdt_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data[bqdt_pkg::DIM_W-1:0];
                    bqdt_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data[bqdt_pkg::DIM_W-1:0];
                    bqdt_pkg::CFG_FAR:    r_far   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= n_raddr;
        r_oob   <= n_oob;
        r_pi    <= n_pi;
        r_pr    <= n_pr;
        r_pc    <= n_pc;
        r_back  <= n_back;
        r_nb    <= n_nb;
        r_nbv   <= n_nbv;
        r_prev  <= n_prev;
        r_dist  <= n_dist;
        r_rdy   <= n_rdy;
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_dist;
    assign o_ready_res = r_rdy;

    `BQDT_ASSERT_NXT(a_last_load_busy, in_acc && !i_kind && (pos_nxt == total), !o_in_ready)
    `BQDT_ASSERT_IMP(a_result_from_read, $rose(o_out_valid), $past(r_state == bqdt_pkg::ST_RD_CAP))
    `BQDT_ASSERT_IMP(a_sweep_in_frame, r_state == bqdt_pkg::ST_WR, {1'b0, r_pi} < total)

endmodule
